// ===== rtl/tanc_pkg.sv =====
// shared widths, constants and payload structs for the triangle area/normal/centroid block
`default_nettype none
package tanc_pkg;

	localparam int CW     = 24;   // vertex and centroid coordinate width
	localparam int EW     = 25;   // edge vector width
	localparam int SUMW   = 26;   // sum of three coordinates
	localparam int CRW    = 50;   // cross product component, |c| < 2^49
	localparam int MAGW   = 49;   // cross product magnitude
	localparam int LOW    = 25;   // low half of a magnitude for squaring
	localparam int HIW    = MAGW - LOW;
	localparam int SQW    = 98;   // square of one component
	localparam int SW     = 100;  // sum of squares
	localparam int ROOTW  = 51;   // integer square root of the sum
	localparam int NBITS  = 31;   // normal magnitude bits, at most 2^30
	localparam int RW     = 168;  // normal residual width, signed
	localparam int NW     = 32;   // normal output width
	localparam int AW     = 52;   // area output width
	localparam int TSH    = 62;   // target scale for the normal compare
	localparam int DIVSH  = 27;   // reciprocal of three, 2^27 scale
	localparam int DIVKW  = 26;
	localparam logic [DIVKW-1:0] DIVK = 26'd44739243;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int NSTEP  = ROOTW;  // back pipeline step stages

	typedef logic signed [CW-1:0] coord_t;

	// word handed from the front part to the back part
	typedef struct packed {
		logic                     nz;
		logic [2:0]               neg;
		logic [2:0][SQW-1:0]      sq;
		logic [SW-1:0]            s;
		logic [2:0][CW-1:0]       center;
	} fb_item_t;

	// state of one word inside the back pipeline
	typedef struct packed {
		logic [SW-1:0]            rem;
		logic [ROOTW-1:0]         root;
		logic                     nz;
		logic [2:0]               neg;
		logic [2:0][RW-1:0]       e;
		logic [2:0][RW-1:0]       w;
		logic [2:0][NBITS-1:0]    m;
		logic [SW-1:0]            s;
		logic [2:0][CW-1:0]       center;
	} bst_t;

endpackage
`default_nettype wire

// ===== rtl/tanc_front.sv =====
// front part: edges, cross product, squared magnitudes and centroid
`default_nettype none
module tanc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tanc_pkg::coord_t   p1_x,
	input  wire tanc_pkg::coord_t   p1_y,
	input  wire tanc_pkg::coord_t   p1_z,
	input  wire tanc_pkg::coord_t   p2_x,
	input  wire tanc_pkg::coord_t   p2_y,
	input  wire tanc_pkg::coord_t   p2_z,
	input  wire tanc_pkg::coord_t   p3_x,
	input  wire tanc_pkg::coord_t   p3_y,
	input  wire tanc_pkg::coord_t   p3_z,
	output logic                    push,
	input  wire logic               q_full,
	output tanc_pkg::fb_item_t      push_item
);
	import tanc_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [CW-1:0]      p1 [3];
	logic signed [CW-1:0]      p2 [3];
	logic signed [CW-1:0]      p3 [3];

	logic signed [EW-1:0]      a_s1 [3];
	logic signed [EW-1:0]      b_s1 [3];
	logic signed [SUMW-1:0]    sum_s1 [3];

	logic signed [CRW-1:0]     c_s2 [3];
	logic [SUMW+DIVKW-2:0]     dprod_s2 [3];
	logic [2:0]                dneg_s2;

	logic [2*HIW-1:0]          hh_s3 [3];
	logic [HIW+LOW-1:0]        hl_s3 [3];
	logic [2*LOW-1:0]          ll_s3 [3];
	logic [2:0]                neg_s3;
	logic                      nz_s3;
	logic [2:0][CW-1:0]        center_s3;

	logic [2:0][SQW-1:0]       sq_s4;
	logic [2:0]                neg_s4;
	logic                      nz_s4;
	logic [2:0][CW-1:0]        center_s4;

	logic [SW-1:0]             s_s5;
	logic [2:0][SQW-1:0]       sq_s5;
	logic [2:0]                neg_s5;
	logic                      nz_s5;
	logic [2:0][CW-1:0]        center_s5;

	assign p1 = '{p1_x, p1_y, p1_z};
	assign p2 = '{p2_x, p2_y, p2_z};
	assign p3 = '{p3_x, p3_y, p3_z};

	assign en       = !v_s5 || !q_full;
	assign in_ready = en;
	assign push     = v_s5 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: edges from the first vertex, coordinate sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]   <= EW'(p2[i]) - EW'(p1[i]);
				b_s1[i]   <= EW'(p3[i]) - EW'(p1[i]);
				sum_s1[i] <= SUMW'(p1[i]) + SUMW'(p2[i]) + SUMW'(p3[i]);
			end
		end
	end

	// stage 2: cross product, centroid magnitude times the reciprocal of three
	logic signed [2*EW-1:0] pr [6];
	logic [SUMW-2:0]        smag [3];
	always_comb begin
		pr[0] = a_s1[1] * b_s1[2];
		pr[1] = a_s1[2] * b_s1[1];
		pr[2] = a_s1[2] * b_s1[0];
		pr[3] = a_s1[0] * b_s1[2];
		pr[4] = a_s1[0] * b_s1[1];
		pr[5] = a_s1[1] * b_s1[0];
		for (int i = 0; i < 3; i++) begin
			smag[i] = sum_s1[i][SUMW-1] ? (SUMW-1)'(-sum_s1[i]) : sum_s1[i][SUMW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2[0] <= CRW'(pr[0] - pr[1]);
			c_s2[1] <= CRW'(pr[2] - pr[3]);
			c_s2[2] <= CRW'(pr[4] - pr[5]);
			for (int i = 0; i < 3; i++) begin
				dprod_s2[i] <= smag[i] * DIVK;
				dneg_s2[i]  <= sum_s1[i][SUMW-1];
			end
		end
	end

	// stage 3: split magnitudes and take partial squares
	logic [MAGW-1:0] mag [3];
	logic [CW-1:0]   quo [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = c_s2[i][CRW-1] ? MAGW'(-c_s2[i]) : c_s2[i][MAGW-1:0];
			quo[i] = dprod_s2[i][DIVSH +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s3[i]     <= mag[i][MAGW-1:LOW] * mag[i][MAGW-1:LOW];
				hl_s3[i]     <= mag[i][MAGW-1:LOW] * mag[i][LOW-1:0];
				ll_s3[i]     <= mag[i][LOW-1:0] * mag[i][LOW-1:0];
				neg_s3[i]    <= c_s2[i][CRW-1];
				center_s3[i] <= dneg_s2[i] ? -quo[i] : quo[i];
			end
			nz_s3 <= (c_s2[0] != '0) || (c_s2[1] != '0) || (c_s2[2] != '0);
		end
	end

	// stage 4: combine partials into exact squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (SQW'(hh_s3[i]) << (2*LOW)) + (SQW'(hl_s3[i]) << (LOW+1))
					+ SQW'(ll_s3[i]);
			end
			neg_s4    <= neg_s3;
			nz_s4     <= nz_s3;
			center_s4 <= center_s3;
		end
	end

	// stage 5: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			s_s5      <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			sq_s5     <= sq_s4;
			neg_s5    <= neg_s4;
			nz_s5     <= nz_s4;
			center_s5 <= center_s4;
		end
	end

	assign push_item = '{nz: nz_s5, neg: neg_s5, sq: sq_s5, s: s_s5, center: center_s5};

endmodule
`default_nettype wire

// ===== rtl/tanc_fifo.sv =====
// short word queue between the front and back parts
`default_nettype none
module tanc_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tanc_pkg::fb_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    empty,
	output tanc_pkg::fb_item_t      head
);
	import tanc_pkg::*;

	fb_item_t        slot_q [QDEPTH];
	logic [QAW-1:0]  wr_q, rd_q;
	logic [QAW:0]    cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tanc_back.sv =====
// back part: bit-per-stage square root and unit normal pipelines, output register
`default_nettype none
module tanc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	output logic                    pop,
	input  wire tanc_pkg::fb_item_t head,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    valid_res,
	output logic [tanc_pkg::AW-1:0] area,
	output logic signed [tanc_pkg::NW-1:0] normal_x,
	output logic signed [tanc_pkg::NW-1:0] normal_y,
	output logic signed [tanc_pkg::NW-1:0] normal_z,
	output tanc_pkg::coord_t        center_x,
	output tanc_pkg::coord_t        center_y,
	output tanc_pkg::coord_t        center_z
);
	import tanc_pkg::*;

	logic       en;
	logic       v_s [NSTEP+1];
	bst_t       pipe_s [NSTEP+1];
	bst_t       nxt [NSTEP+1];
	logic       out_v_q;

	assign en  = !out_v_q || out_ready;
	assign pop = en && !q_empty;

	// entry: residuals start as s for the root and as a^2 * 2^62 - s for the normal
	always_comb begin
		nxt[0].rem    = head.s;
		nxt[0].root   = '0;
		nxt[0].nz     = head.nz;
		nxt[0].neg    = head.neg;
		nxt[0].s      = head.s;
		nxt[0].center = head.center;
		nxt[0].m      = '0;
		for (int i = 0; i < 3; i++) begin
			nxt[0].e[i] = (RW'(head.sq[i]) << TSH) - RW'(head.s);
			nxt[0].w[i] = -RW'(head.s);
		end
	end

	genvar k;
	generate
		for (k = 1; k <= NSTEP; k++) begin : g_step
			localparam int J   = ROOTW - k;
			localparam int NB  = NBITS - k;
			localparam int NBS = (NB > 0) ? NB : 0;
			logic [SW+1:0]        dsub;
			logic [SW+1:0]        rtrial;
			logic signed [RW-1:0] ss;
			logic signed [RW-1:0] ntrial [3];
			always_comb begin
				nxt[k] = pipe_s[k-1];
				// restoring root bit: r^2 grows by 2rb + b^2
				dsub   = ((SW+2)'(pipe_s[k-1].root) << (J+1)) | ((SW+2)'(1) << (2*J));
				rtrial = {2'b00, pipe_s[k-1].rem} - dsub;
				if (!rtrial[SW+1]) begin
					nxt[k].rem     = rtrial[SW-1:0];
					nxt[k].root[J] = 1'b1;
				end
				ss = RW'(pipe_s[k-1].s);
				for (int i = 0; i < 3; i++) begin
					ntrial[i] = '0;
				end
				if (NB >= 0) begin
					// odd trial u = 2m-1+2b, keep e = t - u^2 s and w = u*s
					for (int i = 0; i < 3; i++) begin
						ntrial[i] = $signed(pipe_s[k-1].e[i])
							- ($signed(pipe_s[k-1].w[i]) <<< (NBS+2))
							- (ss <<< (2*NBS+2));
						if (!ntrial[i][RW-1]) begin
							nxt[k].e[i]      = ntrial[i];
							nxt[k].w[i]      = $signed(pipe_s[k-1].w[i]) + (ss <<< (NBS+1));
							nxt[k].m[i][NBS] = 1'b1;
						end
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NSTEP; i++) v_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= !q_empty;
			for (int i = 1; i <= NSTEP; i++) v_s[i] <= v_s[i-1];
			out_v_q <= v_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= nxt[0];
			for (int i = 1; i <= NSTEP; i++) pipe_s[i] <= nxt[i];
		end
	end

	// output register: area = root/2, normals signed and cleared for a flat triangle
	logic [NW-1:0] nmag [3];
	logic [NW-1:0] nval [3];
	bst_t          fin;
	always_comb begin
		fin = pipe_s[NSTEP];
		for (int i = 0; i < 3; i++) begin
			nmag[i] = {1'b0, fin.m[i]};
			nval[i] = !fin.nz ? '0 : (fin.neg[i] ? -nmag[i] : nmag[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valid_res <= fin.nz;
			area      <= fin.nz ? AW'(fin.root >> 1) : '0;
			normal_x  <= nval[0];
			normal_y  <= nval[1];
			normal_z  <= nval[2];
			center_x  <= fin.center[0];
			center_y  <= fin.center[1];
			center_z  <= fin.center[2];
		end
	end

	assign out_valid = out_v_q;

endmodule
`default_nettype wire

// ===== rtl/triangle_area_normal_centroid_top.sv =====
// Triangle area, unit normal and centroid from three Q12.12 vertices. One word is
// accepted per cycle while in_ready is high, one result word leaves per cycle while
// out_ready is high. Words pass 5 front stages, one queue slot, a 52 stage back pipeline
// for the square root and the output register. A four word queue separates the front
// arithmetic from the back pipeline so a stalled output does not stall input until
// the queue fills. Area is floor(|C|/2) in Q28.24, the normal is C/|C| rounded to
// Q1.30 and forced to zero with valid_res low for a degenerate triangle, and the
// centroid is the coordinate sum over three truncated toward zero.
`default_nettype none
module triangle_area_normal_centroid_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tanc_pkg::coord_t   p1_x,
	input  wire tanc_pkg::coord_t   p1_y,
	input  wire tanc_pkg::coord_t   p1_z,
	input  wire tanc_pkg::coord_t   p2_x,
	input  wire tanc_pkg::coord_t   p2_y,
	input  wire tanc_pkg::coord_t   p2_z,
	input  wire tanc_pkg::coord_t   p3_x,
	input  wire tanc_pkg::coord_t   p3_y,
	input  wire tanc_pkg::coord_t   p3_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    valid_res,
	output logic [tanc_pkg::AW-1:0] area,
	output logic signed [tanc_pkg::NW-1:0] normal_x,
	output logic signed [tanc_pkg::NW-1:0] normal_y,
	output logic signed [tanc_pkg::NW-1:0] normal_z,
	output tanc_pkg::coord_t        center_x,
	output tanc_pkg::coord_t        center_y,
	output tanc_pkg::coord_t        center_z
);
	import tanc_pkg::*;

	logic     push, q_full, q_empty, pop;
	fb_item_t push_item, head;

	tanc_front u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.p1_x, .p1_y, .p1_z, .p2_x, .p2_y, .p2_z, .p3_x, .p3_y, .p3_z,
		.push, .q_full, .push_item
	);

	tanc_fifo u_fifo (
		.clk, .arst_n, .push, .push_item, .full(q_full), .pop, .empty(q_empty), .head
	);

	tanc_back u_back (
		.clk, .arst_n, .q_empty, .pop, .head,
		.out_valid, .out_ready, .valid_res, .area,
		.normal_x, .normal_y, .normal_z, .center_x, .center_y, .center_z
	);

	localparam logic signed [NW-1:0] ONE = NW'(1) << (NBITS-1);

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> area == '0 && normal_x == '0 && normal_y == '0
			&& normal_z == '0)
		else $error("flat triangle with nonzero area or normal");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> normal_x <= ONE && normal_x >= -ONE
			&& normal_y <= ONE && normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE)
		else $error("normal component beyond unit");

	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
		else $error("valid triangle with zero normal");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push || pop)
		else $error("queue written while full");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for the triangle area, unit normal and centroid block
`default_nettype none
module tb;
	import tanc_pkg::*;

	typedef struct {
		bit        nondegen;
		bit [51:0] area;
		bit [31:0] nrm [3];
		bit [23:0] ctr [3];
	} tri_result_t;

	class tri_scoreboard;
		tri_result_t pending_q[$];
		int mismatches;
		int checked;

		function automatic bit [31:0] unit_part(longint c, bit [127:0] s);
			bit [191:0] target;
			bit [191:0] odd;
			bit [31:0] m;
			bit [31:0] t;
			longint a;
			a = (c < 0) ? -c : c;
			target = (192'(a) * 192'(a)) << 62;
			m = 0;
			for (int b = 30; b >= 0; b--) begin
				t = m | (32'd1 << b);
				odd = 192'(2 * t - 1);
				if (odd * odd * 192'(s) <= target)
					m = t;
			end
			return (c < 0) ? -m : m;
		endfunction

		function automatic tri_result_t predict(longint p[9]);
			tri_result_t r;
			longint ax, ay, az, bx, by, bz;
			longint cr [3];
			longint mag;
			longint sum;
			bit [127:0] s;
			bit [127:0] t;
			bit [63:0] root;
			ax = p[3] - p[0]; ay = p[4] - p[1]; az = p[5] - p[2];
			bx = p[6] - p[0]; by = p[7] - p[1]; bz = p[8] - p[2];
			cr[0] = ay * bz - az * by;
			cr[1] = az * bx - ax * bz;
			cr[2] = ax * by - ay * bx;
			s = 0;
			for (int k = 0; k < 3; k++) begin
				mag = (cr[k] < 0) ? -cr[k] : cr[k];
				s += 128'(mag) * 128'(mag);
			end
			r.nondegen = (s != 0);
			root = 0;
			for (int b = 51; b >= 0; b--) begin
				t = 128'(root | (64'd1 << b));
				if (t * t <= s)
					root = t[63:0];
			end
			r.area = r.nondegen ? 52'(root >> 1) : '0;
			for (int k = 0; k < 3; k++) begin
				r.nrm[k] = r.nondegen ? unit_part(cr[k], s) : '0;
				sum = p[k] + p[3 + k] + p[6 + k];
				r.ctr[k] = 24'(sum / 3);
			end
			return r;
		endfunction

		function void note_triangle(longint p[9]);
			pending_q = {pending_q, predict(p)};
		endfunction

		function void check_result(tri_result_t got);
			tri_result_t exp_r;
			bit bad;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word at %0t", $time);
				return;
			end
			exp_r = pending_q.pop_front();
			bad = (got.nondegen != exp_r.nondegen) || (got.area != exp_r.area);
			for (int k = 0; k < 3; k++)
				bad |= (got.nrm[k] != exp_r.nrm[k]) || (got.ctr[k] != exp_r.ctr[k]);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t: exp v=%0d a=%h n=%h %h %h c=%h %h %h",
						$time, exp_r.nondegen, exp_r.area, exp_r.nrm[0], exp_r.nrm[1],
						exp_r.nrm[2], exp_r.ctr[0], exp_r.ctr[1], exp_r.ctr[2]);
					$display("    got v=%0d a=%h n=%h %h %h c=%h %h %h",
						got.nondegen, got.area, got.nrm[0], got.nrm[1], got.nrm[2],
						got.ctr[0], got.ctr[1], got.ctr[2]);
				end
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	coord_t vtx [9] = '{default: '0};
	logic out_valid;
	logic out_ready = 0;
	logic valid_res;
	logic [AW-1:0] area;
	logic signed [NW-1:0] normal_x, normal_y, normal_z;
	coord_t center_x, center_y, center_z;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent = 0;
	int degenerate_sent = 0;
	tri_scoreboard sb;

	triangle_area_normal_centroid_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.p1_x(vtx[0]), .p1_y(vtx[1]), .p1_z(vtx[2]),
		.p2_x(vtx[3]), .p2_y(vtx[4]), .p2_z(vtx[5]),
		.p3_x(vtx[6]), .p3_y(vtx[7]), .p3_z(vtx[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.valid_res(valid_res), .area(area),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.center_x(center_x), .center_y(center_y), .center_z(center_z)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		tri_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.nondegen = valid_res;
			got.area = area;
			got.nrm[0] = normal_x; got.nrm[1] = normal_y; got.nrm[2] = normal_z;
			got.ctr[0] = center_x; got.ctr[1] = center_y; got.ctr[2] = center_z;
			sb.check_result(got);
		end
	end

	// one triangle word, with an optional gap before it
	task automatic send_triangle(longint p[9]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		for (int k = 0; k < 9; k++)
			vtx[k] <= coord_t'(p[k]);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_triangle(p);
		sent++;
		if (sb.pending_q[$].nondegen == 0)
			degenerate_sent++;
	endtask

	function automatic longint rnd_coord(int kind);
		case (kind)
			0: return longint'($urandom_range(16777215)) - 8388608;
			1: return longint'($urandom_range(8191)) - 4096;
			2: return ($urandom_range(1)) ? 64'sd8388607 - longint'($urandom_range(3))
				: -64'sd8388608 + longint'($urandom_range(3));
			default: return longint'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	task automatic send_random();
		longint p[9];
		int kind;
		int mode;
		longint k;
		kind = $urandom_range(3);
		mode = $urandom_range(9);
		for (int i = 0; i < 9; i++)
			p[i] = rnd_coord(($urandom_range(3) == 0) ? $urandom_range(3) : kind);
		if (mode == 0) begin
			// collinear: third vertex on the line through the first two
			k = longint'($urandom_range(4)) - 2;
			for (int i = 0; i < 3; i++) begin
				p[i] = rnd_coord(1);
				p[3 + i] = rnd_coord(1);
				p[6 + i] = p[i] + k * (p[3 + i] - p[i]);
			end
		end else if (mode == 1) begin
			// coincident vertices
			for (int i = 0; i < 3; i++)
				p[3 + $urandom_range(1) * 3 + i] = p[i];
		end else if (mode == 2) begin
			// triangle in an axis plane
			k = p[$urandom_range(2)];
			for (int i = 0; i < 3; i++)
				p[i * 3 + 2] = k;
		end
		send_triangle(p);
	endtask

	task automatic send_directed();
		longint d [20][9];
		longint mx, mn;
		mx = 8388607; mn = -8388608;
		d = '{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{mx, mx, mx, mx, mx, mx, mx, mx, mx},
			'{mn, mn, mn, mn, mn, mn, mn, mn, mn},
			'{mn, mn, mn, mx, mn, mn, mn, mx, mn},
			'{mn, mn, mn, mx, mn, mn, mn, mx, mx},
			'{mx, mx, mx, mn, mx, mx, mx, mn, mx},
			'{mn, mx, mn, mx, mn, mx, mn, mn, mx},
			'{0, 0, 0, 4096, 0, 0, 0, 4096, 0},
			'{0, 0, 0, 0, 4096, 0, 4096, 0, 0},
			'{0, 0, 0, 0, 0, 4096, 4096, 0, 0},
			'{0, 0, 0, 1, 0, 0, 0, 1, 0},
			'{0, 0, 0, 1, 1, 1, 2, 2, 2},
			'{5, 7, 9, 5, 7, 9, 5, 7, 9},
			'{-1, 0, 0, 0, -1, 0, 0, 0, -1},
			'{-1, -1, -1, -1, -1, 0, 0, 0, 0},
			'{1, 1, 1, 1, 1, 0, 0, 0, 0},
			'{mn, mn, mn, mn, mn, mn, mx, mx, mx},
			'{4096, 0, 0, 0, 4096, 0, 0, 0, 4096},
			'{3, -5, 7, -11, 13, -17, 19, -23, 29},
			'{mn, 0, mx, 0, mx, mn, mx, mn, 0}
		};
		foreach (d[i])
			send_triangle(d[i]);
	endtask

	initial begin
		int guard;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_directed();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
			recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
			repeat (510)
				send_random();
		end
		in_valid <= 0;
		guard = 0;
		while (sb.pending_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
		$display("sent %0d triangles (%0d degenerate), checked %0d result words, %0d mismatches",
			sent, degenerate_sent, sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("[triangle_area_normal_centroid_top] OK");
		end else begin
			$display("%0d expected results never arrived", sb.pending_q.size());
			$display("[triangle_area_normal_centroid_top] ERROR");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("run timed out");
		$display("[triangle_area_normal_centroid_top] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
